@@ rtl/rce_pkg.sv @@
// ----------------------------------------------------------------------------
// rce_pkg
// Shared widths, function codes, register indexes and the elaboration-time
// math that builds the raised-cosine ease table.
// ----------------------------------------------------------------------------
package rce_pkg;

    localparam int unsigned EASE_TABLE_DEPTH_DEF = 1024;
    localparam int unsigned HALF_W      = 15;
    localparam int unsigned PHASE_W     = 16;
    localparam int unsigned FUNC_W      = 3;
    localparam int unsigned STEP_W      = 16;
    localparam int unsigned EASED_W     = 16;
    localparam int unsigned FLOOR_W     = 16;
    localparam int unsigned SPAN_W      = 17;
    localparam int unsigned CFG_DATA_W  = 17;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned EASE_W      = 17;
    localparam int unsigned DELTA_W     = 18;

    localparam logic [PHASE_W-1:0] HALF_TURN = 16'd32768;
    localparam logic [PHASE_W-1:0] MID_TURN  = 16'd16384;

    localparam logic [FUNC_W-1:0] FUNC_RAISE = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOWER = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_MID   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FLOOR = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TOP   = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_FLOOR = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPAN  = 1'b1;

    localparam logic [SPAN_W-1:0] SPAN_RESET = 17'd1608;

    localparam longint unsigned PI_Q28       = 64'd843314857;
    localparam longint          ONE_Q28      = 64'sd268435456;
    localparam int unsigned     TAYLOR_TERMS = 12;
    localparam int unsigned     TAYLOR_DIV [TAYLOR_TERMS] =
        '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552};

    // Ease fraction in Q16 for an angle x in Q28, by a truncated Taylor series.
    function automatic logic [EASE_W-1:0] cos_to_ease(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          c;
        longint          v;
        int unsigned     n;
        x2   = (x * x) >> 28;
        term = longint'(ONE_Q28);
        c    = 0;
        for (n = 0; n < TAYLOR_TERMS; n++) begin
            if (n[0]) begin
                c = c - longint'(term);
            end else begin
                c = c + longint'(term);
            end
            term = ((term * x2) >> 28) / 64'(TAYLOR_DIV[n]);
        end
        v = (ONE_Q28 - c + 64'sd4096) / 64'sd8192;
        if (v < 0) begin
            v = 0;
        end else if (v > 65536) begin
            v = 65536;
        end
        return EASE_W'(v);
    endfunction

endpackage

@@ rtl/rce_in_if.sv @@
// ----------------------------------------------------------------------------
// rce_in_if
// Input channel: one phase command item per handshake.
// ----------------------------------------------------------------------------
interface rce_in_if import rce_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [STEP_W-1:0]   step_amount;

    modport source (output valid, output func, output step_amount, input ready);
    modport sink   (input valid, input func, input step_amount, output ready);

endinterface

@@ rtl/rce_out_if.sv @@
// ----------------------------------------------------------------------------
// rce_out_if
// Output channel: one eased value item per handshake.
// ----------------------------------------------------------------------------
interface rce_out_if import rce_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [EASED_W-1:0]  eased_value;
    logic [PHASE_W-1:0]         phase_now;
    logic                       at_top;
    logic                       at_floor;

    modport source (output valid, output eased_value, output phase_now,
                    output at_top, output at_floor, input ready);
    modport sink   (input valid, input eased_value, input phase_now,
                    input at_top, input at_floor, output ready);

endinterface

@@ rtl/raised_cosine_ease_generator_core.sv @@
// ----------------------------------------------------------------------------
// raised_cosine_ease_generator_core
// Raised-cosine ease-in/ease-out value generator with a clamped phase.
// ----------------------------------------------------------------------------
// Each input item moves the phase (raise, lower, run to the midpoint, or jump
// to either end; the spare codes keep it) and produces exactly one output
// item with the eased value, the new phase and the end flags. The user must
// write floor and span through the configuration port only while no item is
// in flight; the block itself does not enforce this. The pipeline has five
// register stages: phase update, table read, table interpolation, span
// multiply, and round with saturation into the output register. One item is
// accepted every cycle while the receiver does not stall. The phase register
// closes the only loop, so back-to-back items need no spacing.
// Every stage holds its item while the next one is full and stalled; bubbles
// are squeezed out, so input ready drops only when all five stages are full
// and the receiver is stalling. Reset empties the pipeline, puts the phase
// at the floor position, the floor at zero and the span at 1608.
// ----------------------------------------------------------------------------
module raised_cosine_ease_generator_core import rce_pkg::*; #(
    parameter int unsigned EASE_TABLE_DEPTH = EASE_TABLE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    rce_in_if.sink                 i_item,
    rce_out_if.source              o_item
);

    localparam int unsigned ROM_N      = EASE_TABLE_DEPTH + 1;
    localparam int unsigned IDX_W      = $clog2(ROM_N);
    localparam int unsigned ROM_W      = DELTA_W + EASE_W;
    localparam int unsigned HALF_DEPTH = EASE_TABLE_DEPTH / 2;
    localparam int unsigned POS_W      = 32;
    localparam int unsigned INTERP_W   = DELTA_W + HALF_W + 1;
    localparam int unsigned PROD_W     = EASE_W + 1 + SPAN_W;
    localparam int unsigned SUM_W      = 20;

    typedef logic [ROM_W-1:0] t_rom [ROM_N];

    function automatic t_rom build_rom();
        t_rom                       rom;
        logic [EASE_W-1:0]          pts [ROM_N];
        int unsigned                k;
        int unsigned                m;
        longint unsigned            x;
        logic signed [DELTA_W-1:0]  d;
        for (k = 0; k < ROM_N; k++) begin
            m = (k <= HALF_DEPTH) ? k : EASE_TABLE_DEPTH - k;
            x = (PI_Q28 * 64'(m)) / EASE_TABLE_DEPTH;
            pts[k] = cos_to_ease(x);
            if (k > HALF_DEPTH) begin
                pts[k] = 17'h10000 - pts[k];
            end
        end
        for (k = 0; k < EASE_TABLE_DEPTH; k++) begin
            d = $signed({1'b0, pts[k+1]}) - $signed({1'b0, pts[k]});
            rom[k] = {d, pts[k]};
        end
        rom[EASE_TABLE_DEPTH] = {{DELTA_W{1'b0}}, pts[EASE_TABLE_DEPTH]};
        return rom;
    endfunction

    localparam t_rom ROM_DATA = build_rom();

    logic signed [FLOOR_W-1:0] r_floor;
    logic signed [SPAN_W-1:0]  r_span;

    logic [PHASE_W-1:0]        r_phase;
    logic [PHASE_W-1:0]        n_phase;
    logic                      r_s0_valid;

    logic                      r_s1_valid;
    logic [ROM_W-1:0]          r_s1_word;
    logic [HALF_W-1:0]         r_s1_frac;
    logic [PHASE_W-1:0]        r_s1_phase;

    logic                      r_s2_valid;
    logic [EASE_W-1:0]         r_s2_ease;
    logic [EASE_W-1:0]         n_s2_ease;
    logic [PHASE_W-1:0]        r_s2_phase;

    logic                      r_s3_valid;
    logic signed [PROD_W-1:0]  r_s3_prod;
    logic signed [PROD_W-1:0]  n_s3_prod;
    logic [PHASE_W-1:0]        r_s3_phase;

    logic                      r_out_valid;
    logic signed [EASED_W-1:0] r_out_eased;
    logic signed [EASED_W-1:0] n_out_eased;
    logic [PHASE_W-1:0]        r_out_phase;
    logic                      r_out_top;
    logic                      r_out_floor;

    logic                      en0, en1, en2, en3, en_out;
    logic                      accept;
    logic [PHASE_W:0]          raise_sum;
    logic [POS_W-1:0]          pos;
    logic [IDX_W-1:0]          rd_idx;
    logic signed [DELTA_W-1:0] delta;
    logic signed [INTERP_W-1:0] interp_num;
    logic signed [INTERP_W-1:0] ease_wide;
    logic signed [PROD_W-1:0]  scaled_round;
    logic signed [SUM_W-1:0]   floor_ext;
    logic signed [SUM_W-1:0]   span_ext;
    logic signed [SUM_W-1:0]   eased_sum;
    logic                      s3_top;

    assign en_out = !r_out_valid || o_item.ready;
    assign en3    = !r_s3_valid || en_out;
    assign en2    = !r_s2_valid || en3;
    assign en1    = !r_s1_valid || en2;
    assign en0    = !r_s0_valid || en1;
    assign accept = i_item.valid && en0;

    assign i_item.ready = en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= '0;
            r_span  <= SPAN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FLOOR: r_floor <= i_cfg_data[FLOOR_W-1:0];
                REG_SPAN:  r_span  <= i_cfg_data[SPAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign raise_sum = {1'b0, r_phase} + {1'b0, i_item.step_amount};

    always_comb begin
        n_phase = r_phase;
        case (i_item.func)
            FUNC_RAISE: begin
                n_phase = (raise_sum > {1'b0, HALF_TURN}) ? HALF_TURN : raise_sum[PHASE_W-1:0];
            end
            FUNC_LOWER: begin
                n_phase = (r_phase > i_item.step_amount) ? r_phase - i_item.step_amount : '0;
            end
            FUNC_MID: begin
                if (r_phase > MID_TURN) begin
                    n_phase = (r_phase - MID_TURN > i_item.step_amount) ?
                              r_phase - i_item.step_amount : MID_TURN;
                end else if (r_phase < MID_TURN) begin
                    n_phase = (MID_TURN - r_phase > i_item.step_amount) ?
                              raise_sum[PHASE_W-1:0] : MID_TURN;
                end
            end
            FUNC_FLOOR: n_phase = '0;
            FUNC_TOP:   n_phase = HALF_TURN;
            default:    n_phase = r_phase;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_s0_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
            end
            if (en0) begin
                r_s0_valid <= i_item.valid;
            end
        end
    end

    assign pos    = POS_W'(r_phase) * POS_W'(EASE_TABLE_DEPTH);
    assign rd_idx = pos[HALF_W +: IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_word  <= ROM_DATA[rd_idx];
            r_s1_frac  <= pos[HALF_W-1:0];
            r_s1_phase <= r_phase;
        end
    end

    assign delta      = r_s1_word[ROM_W-1:EASE_W];
    assign interp_num = delta * $signed({1'b0, r_s1_frac}) + INTERP_W'(16384);
    assign ease_wide  = $signed({{(INTERP_W-EASE_W){1'b0}}, r_s1_word[EASE_W-1:0]})
                      + (interp_num >>> HALF_W);
    assign n_s2_ease  = ease_wide[EASE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_ease  <= n_s2_ease;
            r_s2_phase <= r_s1_phase;
        end
    end

    assign n_s3_prod = $signed({1'b0, r_s2_ease}) * r_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_prod  <= n_s3_prod;
            r_s3_phase <= r_s2_phase;
        end
    end

    assign s3_top       = (r_s3_phase == HALF_TURN);
    assign scaled_round = (r_s3_prod + PROD_W'(32768)) >>> 16;
    assign floor_ext    = {{(SUM_W-FLOOR_W){r_floor[FLOOR_W-1]}}, r_floor};
    assign span_ext     = {{(SUM_W-SPAN_W){r_span[SPAN_W-1]}}, r_span};
    assign eased_sum    = floor_ext + (s3_top ? span_ext : scaled_round[SUM_W-1:0]);

    always_comb begin
        if (eased_sum[SUM_W-1:EASED_W-1] == '0 || eased_sum[SUM_W-1:EASED_W-1] == '1) begin
            n_out_eased = eased_sum[EASED_W-1:0];
        end else if (eased_sum[SUM_W-1]) begin
            n_out_eased = {1'b1, {(EASED_W-1){1'b0}}};
        end else begin
            n_out_eased = {1'b0, {(EASED_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_eased <= n_out_eased;
            r_out_phase <= r_s3_phase;
            r_out_top   <= s3_top;
            r_out_floor <= (r_s3_phase == '0);
        end
    end

    assign o_item.valid       = r_out_valid;
    assign o_item.eased_value = r_out_eased;
    assign o_item.phase_now   = r_out_phase;
    assign o_item.at_top      = r_out_top;
    assign o_item.at_floor    = r_out_floor;

endmodule

@@ rtl/rce_checker.sv @@
// ----------------------------------------------------------------------------
// rce_checker
// Port-level checks for the ease generator, bound to the top level.
// ----------------------------------------------------------------------------
module rce_checker import rce_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic signed [EASED_W-1:0] i_eased_value,
    input logic [PHASE_W-1:0]        i_phase_now,
    input logic                      i_at_top,
    input logic                      i_at_floor
);

    // A reset cycle leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_eased_value, i_phase_now, i_at_top, i_at_floor}))
        else $error("stalled result changed or vanished");

    // With nothing waiting at the output, the pipeline cannot be blocked.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with an empty output stage");

    // An item waits at the input only while a result waits at the output.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input item stalled without a stalled result");

    a_flags_match_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_phase_now <= HALF_TURN
            && i_at_top == (i_phase_now == HALF_TURN)
            && i_at_floor == (i_phase_now == '0))
        else $error("phase out of range or end flags inconsistent");

endmodule

bind raised_cosine_ease_generator_core rce_checker u_rce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_item.valid),
    .i_out_ready   (o_item.ready),
    .i_eased_value (o_item.eased_value),
    .i_phase_now   (o_item.phase_now),
    .i_at_top      (o_item.at_top),
    .i_at_floor    (o_item.at_floor)
);

@@ tb/raised_cosine_ease_generator_core_tb.sv @@
// ----------------------------------------------------------------------------
// raised_cosine_ease_generator_core_tb
// Self-checking testbench for the raised-cosine ease generator.
// ----------------------------------------------------------------------------
// Phase commands are sent over the input channel. A local model predicts the
// phase, the end flags and the eased value of every item from its own ease
// table. Each output item is compared with the oldest prediction. Directed
// items cover the phase ends, the midpoint run, the spare command codes and
// output saturation. Random traffic follows, under changing floor and span
// settings, with random stalls on both channels in two of its three runs.
// ----------------------------------------------------------------------------
module raised_cosine_ease_generator_core_tb import rce_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     LUT_DEPTH    = EASE_TABLE_DEPTH_DEF;
    localparam longint TOP_PH       = 32768;
    localparam longint MID_PH       = 16384;
    localparam longint ANGLE_PI_Q28 = 64'd843314857;
    localparam int     SERIES_LEN   = 12;

    typedef struct packed {
        logic signed [EASED_W-1:0] eased;
        logic [PHASE_W-1:0]        phase;
        logic                      top;
        logic                      bottom;
    } t_ease_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    rce_in_if  in_if ();
    rce_out_if out_if ();

    raised_cosine_ease_generator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (in_if.sink),
        .o_item      (out_if.source)
    );

    longint       ease_lut [0:LUT_DEPTH];
    longint       cur_phase;
    longint       cfg_floor;
    longint       cfg_span;
    t_ease_result pending_q [$];
    int           err_count;
    int unsigned  src_idle_pct;
    int unsigned  sink_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint raised_cos_q16(int k);
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned term;
        longint unsigned div;
        longint          acc;
        longint          v;
        ang  = (ANGLE_PI_Q28 * longint'(k)) / LUT_DEPTH;
        ang2 = (ang * ang) >> 28;
        term = 64'd1 << 28;
        acc  = 0;
        for (int n = 0; n < SERIES_LEN; n++) begin
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
            div  = (2 * n + 1) * (2 * n + 2);
            term = ((term * ang2) >> 28) / div;
        end
        v = ((64'sd1 <<< 28) - acc + 4096) / 8192;
        if (v < 0) begin
            v = 0;
        end else if (v > 65536) begin
            v = 65536;
        end
        return v;
    endfunction

    function automatic void build_ease_lut();
        for (int k = 0; k <= LUT_DEPTH / 2; k++) begin
            ease_lut[k] = raised_cos_q16(k);
        end
        for (int k = LUT_DEPTH / 2 + 1; k <= LUT_DEPTH; k++) begin
            ease_lut[k] = 65536 - ease_lut[LUT_DEPTH - k];
        end
    endfunction

    function automatic longint ease_frac_q16(longint p);
        longint pos;
        longint idx;
        longint frac;
        longint base;
        longint num;
        pos  = p * LUT_DEPTH;
        idx  = pos / TOP_PH;
        frac = pos % TOP_PH;
        if (idx >= LUT_DEPTH) begin
            return ease_lut[LUT_DEPTH];
        end
        base = ease_lut[idx];
        num  = (ease_lut[idx + 1] - base) * frac + TOP_PH / 2;
        return base + (num >>> 15);
    endfunction

    function automatic t_ease_result apply_command(logic [FUNC_W-1:0] f,
                                                   logic [STEP_W-1:0] s);
        longint       p;
        longint       amt;
        longint       v;
        t_ease_result r;
        p   = cur_phase;
        amt = longint'(s);
        case (f)
            FUNC_RAISE: p = (p + amt > TOP_PH) ? TOP_PH : p + amt;
            FUNC_LOWER: p = (p > amt) ? p - amt : 0;
            FUNC_MID: begin
                if (p > MID_PH) begin
                    p = (p - MID_PH > amt) ? p - amt : MID_PH;
                end else if (p < MID_PH) begin
                    p = (MID_PH - p > amt) ? p + amt : MID_PH;
                end
            end
            FUNC_FLOOR: p = 0;
            FUNC_TOP:   p = TOP_PH;
            default: ;
        endcase
        cur_phase = p;
        if (p == TOP_PH) begin
            v = cfg_floor + cfg_span;
        end else begin
            v = cfg_floor + ((ease_frac_q16(p) * cfg_span + 32768) >>> 16);
        end
        if (v > 32767) begin
            v = 32767;
        end else if (v < -32768) begin
            v = -32768;
        end
        r.eased  = v[EASED_W-1:0];
        r.phase  = p[PHASE_W-1:0];
        r.top    = (p == TOP_PH);
        r.bottom = (p == 0);
        return r;
    endfunction

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        t_ease_result got;
        t_ease_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.eased  = out_if.eased_value;
            got.phase  = out_if.phase_now;
            got.top    = out_if.at_top;
            got.bottom = out_if.at_floor;
            if (pending_q.size() == 0) begin
                if (err_count < 10) begin
                    $display("unexpected item: eased=%0d phase=%0d top=%0b floor=%0b",
                             got.eased, got.phase, got.top, got.bottom);
                end
                err_count++;
            end else begin
                want = pending_q.pop_front();
                if (got !== want) begin
                    if (err_count < 10) begin
                        $display("mismatch: expected eased=%0d phase=%0d top=%0b floor=%0b",
                                 want.eased, want.phase, want.top, want.bottom);
                        $display("          actual   eased=%0d phase=%0d top=%0b floor=%0b",
                                 got.eased, got.phase, got.top, got.bottom);
                    end
                    err_count++;
                end
            end
        end
    end

    task automatic send_item(logic [FUNC_W-1:0] f, logic [STEP_W-1:0] s);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        in_if.valid       <= 1'b1;
        in_if.func        <= f;
        in_if.step_amount <= s;
        do @(posedge i_clk); while (!in_if.ready);
        pending_q.push_back(apply_command(f, s));
    endtask

    task automatic wait_results_done();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_ease_range(logic [CFG_DATA_W-1:0] floor_data,
                                  logic [CFG_DATA_W-1:0] span_data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_FLOOR;
        i_cfg_data  <= floor_data;
        @(posedge i_clk);
        i_cfg_index <= REG_SPAN;
        i_cfg_data  <= span_data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_floor = longint'(signed'(floor_data[FLOOR_W-1:0]));
        cfg_span  = longint'(signed'(span_data));
    endtask

    task automatic test_phase_commands();
        send_item(FUNC_FLOOR, 16'd0);
        send_item(FUNC_RAISE, 16'd1);
        send_item(FUNC_RAISE, 16'd31);
        send_item(FUNC_RAISE, 16'd12345);
        send_item(FUNC_RAISE, 16'hFFFF);
        send_item(FUNC_RAISE, 16'd0);
        send_item(FUNC_LOWER, 16'd1);
        send_item(FUNC_LOWER, 16'hFFFF);
        send_item(FUNC_LOWER, 16'd0);
        send_item(FUNC_MID, 16'd100);
        send_item(FUNC_MID, 16'hFFFF);
        send_item(FUNC_MID, 16'd5);
        send_item(FUNC_TOP, 16'hAAAA);
        send_item(FUNC_MID, 16'd10);
        send_item(FUNC_MID, 16'h5555);
        for (int c = int'(FUNC_TOP) + 1; c < (1 << FUNC_W); c++) begin
            send_item(FUNC_W'(c), 16'h8000);
        end
        wait_results_done();
    endtask

    task automatic test_saturation();
        set_ease_range(17'h07FFF, 17'h0FFFF);
        send_item(FUNC_TOP, 16'd0);
        send_item(FUNC_MID, 16'hFFFF);
        wait_results_done();
        set_ease_range(17'h18000, 17'h10000);
        send_item(FUNC_TOP, 16'd0);
        send_item(FUNC_LOWER, 16'd777);
        send_item(FUNC_FLOOR, 16'd0);
        wait_results_done();
        set_ease_range(17'h08000, 17'h0FFFF);
        send_item(FUNC_TOP, 16'd0);
        send_item(FUNC_LOWER, 16'd9000);
        wait_results_done();
    endtask

    task automatic pick_random_range();
        logic [CFG_DATA_W-1:0] fd;
        logic [CFG_DATA_W-1:0] sd;
        case ($urandom_range(0, 5))
            0:       fd = 17'h08000;
            1:       fd = 17'h07FFF;
            2:       fd = '0;
            3:       fd = CFG_DATA_W'($urandom());
            default: fd = CFG_DATA_W'(int'($urandom_range(0, 2048)) - 1024);
        endcase
        fd[CFG_DATA_W-1] = $urandom_range(0, 1);
        case ($urandom_range(0, 7))
            0:       sd = 17'h0FFFF;
            1:       sd = 17'h10001;
            2:       sd = 17'h10000;
            3:       sd = SPAN_RESET;
            4:       sd = CFG_DATA_W'($urandom());
            default: sd = CFG_DATA_W'(int'($urandom_range(0, 8192)) - 4096);
        endcase
        set_ease_range(fd, sd);
    endtask

    task automatic test_random_traffic(int n_items);
        logic [FUNC_W-1:0] f;
        logic [STEP_W-1:0] s;
        int unsigned       r;
        for (int i = 0; i < n_items; i++) begin
            if (i % 100 == 0) begin
                wait_results_done();
                pick_random_range();
            end
            r = $urandom_range(0, 99);
            if (r < 35) begin
                f = FUNC_RAISE;
            end else if (r < 70) begin
                f = FUNC_LOWER;
            end else if (r < 85) begin
                f = FUNC_MID;
            end else if (r < 91) begin
                f = FUNC_FLOOR;
            end else if (r < 97) begin
                f = FUNC_TOP;
            end else begin
                f = FUNC_TOP + FUNC_W'($urandom_range(1, 3));
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
                s = STEP_W'($urandom_range(0, 1023));
            end else if (r < 80) begin
                s = STEP_W'($urandom_range(0, 8191));
            end else if (r < 92) begin
                s = STEP_W'($urandom());
            end else begin
                case ($urandom_range(0, 3))
                    0:       s = '0;
                    1:       s = '1;
                    2:       s = 16'd16384;
                    default: s = 16'd32768;
                endcase
            end
            send_item(f, s);
        end
        wait_results_done();
    endtask

    task automatic finish_run();
        int guard;
        in_if.valid <= 1'b0;
        guard = 0;
        while (pending_q.size() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        err_count += pending_q.size();
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    endtask

    initial begin
        err_count     = 0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= REG_FLOOR;
        i_cfg_data        <= '0;
        in_if.valid       <= 1'b0;
        in_if.func        <= FUNC_RAISE;
        in_if.step_amount <= '0;
        build_ease_lut();
        cur_phase = 0;
        cfg_floor = 0;
        cfg_span  = longint'(SPAN_RESET);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_phase_commands();
        test_saturation();

        src_idle_pct  = 18;
        sink_idle_pct = 54;
        test_random_traffic(300);
        src_idle_pct  = 54;
        sink_idle_pct = 18;
        test_random_traffic(300);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic(300);

        finish_run();
    end

endmodule

@@ sim.f @@
rtl/rce_pkg.sv
rtl/rce_in_if.sv
rtl/rce_out_if.sv
rtl/raised_cosine_ease_generator_core.sv
rtl/rce_checker.sv
tb/raised_cosine_ease_generator_core_tb.sv
